### src/gif_lzw_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// GIF LZW encoder assertion macros
// Shared assertion forms, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_ENCODER_TOP_DEFINES_SVH
`define GIF_LZW_ENCODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define GLE_NEVER(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(prop)) else $error(msg);
`else
`define GLE_ASSERT(lbl, prop, msg)
`define GLE_NEVER(lbl, prop, msg)
`endif
`endif

### src/gle_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder package
// Shared constants, types and helper functions.
// ----------------------------------------------------------------------------
package gle_pkg;
    localparam int MAX_CODE_BITS = 12;
    localparam int DICT_SLOTS    = 8192;
    localparam int ADDR_W        = $clog2(DICT_SLOTS);
    localparam int KEY_W         = MAX_CODE_BITS + 8;
    localparam int WORD_W        = 1 + KEY_W + MAX_CODE_BITS;
    localparam logic [15:0] HASH_MUL = 16'd40503;
    localparam logic [3:0]  MIN_RESET = 4'd8;

    typedef struct packed {
        logic [7:0] k;
        logic       last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    function automatic logic [3:0] eff_min(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v < 4'd2) r = 4'd2;
        if (v > 4'd8) r = 4'd8;
        return r;
    endfunction
endpackage

### src/gle_front.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder front end
// Accepts pixels, masks them to the root code size and queues them.
// ----------------------------------------------------------------------------
module gle_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_pixel,
    input  logic                 i_last_pixel,
    input  logic [3:0]           i_min,
    input  logic                 i_pop,
    output gle_pkg::t_qhead      o_head
);
    gle_pkg::t_item r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic [7:0] kmask;

    assign kmask      = 8'((9'(1) << i_min) - 9'd1);
    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_buf[r_wp].k    <= i_pixel & kmask;
                r_buf[r_wp].last <= i_last_pixel;
                r_wp             <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

### src/gle_engine.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder engine
// Dictionary probe and insert, code emission, bit packing and byte output.
// ----------------------------------------------------------------------------
`include "gif_lzw_encoder_top_defines.svh"
module gle_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [3:0]           i_cfg_data,
    input  gle_pkg::t_qhead      i_head,
    output logic                 o_pop,
    output logic [3:0]           o_min,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_byte
);
    localparam int CW = gle_pkg::MAX_CODE_BITS;
    localparam int AW = gle_pkg::ADDR_W;
    localparam logic [CW:0] LIMIT = (CW+1)'(1) << CW;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_CMP, S_DRAIN, S_TAIL, S_END, S_FLUSH
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [3:0]    r_min, n_min, m, r_width, n_width;
    logic [CW-1:0] r_prefix, n_prefix;
    logic [CW:0]   r_next, n_next;
    logic [19:0]   r_acc, n_acc;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_start, n_start, r_last, n_last;
    logic [7:0]    r_k, n_k;
    logic [gle_pkg::KEY_W-1:0] r_key, n_key;
    logic [AW-1:0] r_h, n_h;
    logic          r_ov, r_ol;
    logic [7:0]    r_ob;

    logic [gle_pkg::WORD_W-1:0] mem [gle_pkg::DICT_SLOTS];
    logic [gle_pkg::WORD_W-1:0] r_rd, wd;
    logic          we;

    logic          put, put_data, emit, emit_last, can_emit;
    logic [CW-1:0] pc, clr_code, end_code, rd_code;
    logic [gle_pkg::KEY_W-1:0] rd_key, hkey;
    logic          rd_valid;
    logic [CW:0]   mask13;
    logic [28:0]   prod;

    assign m         = gle_pkg::eff_min(r_min);
    assign clr_code  = CW'(1) << m;
    assign end_code  = clr_code + CW'(1);
    assign can_emit  = !r_ov || i_out_ready;
    assign rd_valid  = r_rd[gle_pkg::WORD_W-1];
    assign rd_key    = r_rd[CW +: gle_pkg::KEY_W];
    assign rd_code   = r_rd[CW-1:0];
    assign hkey      = {r_prefix, i_head.item.k};
    assign prod      = hkey[12:0] * gle_pkg::HASH_MUL;
    assign mask13    = ((CW+1)'(1) << r_width) - (CW+1)'(1);

    always_comb begin
        logic [3:0] mi;
        mi = gle_pkg::eff_min(i_cfg_data);
        n_state = r_state;   n_ret = r_ret;     n_min = r_min;
        n_width = r_width;   n_prefix = r_prefix; n_next = r_next;
        n_acc = r_acc;       n_cnt = r_cnt;     n_start = r_start;
        n_last = r_last;     n_k = r_k;         n_key = r_key;
        n_h = r_h;
        we = 1'b0; wd = '0; o_pop = 1'b0;
        put = 1'b0; put_data = 1'b0; pc = r_prefix;
        emit = 1'b0; emit_last = 1'b0;
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                if (r_h == {AW{1'b1}}) n_state = S_IDLE;
                n_h = r_h + AW'(1);
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_k    = i_head.item.k;
                    n_last = i_head.item.last;
                    if (r_start) begin
                        put      = 1'b1;
                        pc       = clr_code;
                        n_prefix = CW'(i_head.item.k);
                        n_start  = 1'b0;
                        n_ret    = S_TAIL;
                        n_state  = S_DRAIN;
                    end else begin
                        n_key   = hkey;
                        n_h     = prod[AW-1:0];
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (rd_valid && rd_key == r_key) begin
                    n_prefix = rd_code;
                    n_state  = S_TAIL;
                end else if (rd_valid) begin
                    n_h     = r_h + AW'(1);
                    n_state = S_READ;
                end else begin
                    put      = 1'b1;
                    put_data = 1'b1;
                    if (r_next < LIMIT) begin
                        we     = 1'b1;
                        wd     = {1'b1, r_key, r_next[CW-1:0]};
                        n_next = r_next + (CW+1)'(1);
                    end
                    n_prefix = CW'(r_k);
                    n_ret    = S_TAIL;
                    n_state  = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_cnt >= 5'd8) emit = can_emit;
                else n_state = r_ret;
            end
            S_TAIL: begin
                if (r_last) begin
                    put      = 1'b1;
                    put_data = 1'b1;
                    n_ret    = S_END;
                    n_state  = S_DRAIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_END: begin
                put     = 1'b1;
                pc      = end_code;
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (r_cnt == 5'd0) begin
                    n_prefix = '0;
                    n_next   = ((CW+1)'(1) << m) + (CW+1)'(2);
                    n_width  = m + 4'd1;
                    n_start  = 1'b1;
                    n_h      = '0;
                    n_state  = S_CLEAR;
                end else begin
                    emit      = can_emit;
                    emit_last = (r_cnt <= 5'd8);
                end
            end
            default: n_state = S_CLEAR;
        endcase
        if (put) begin
            n_acc = r_acc | (20'(pc & mask13[CW-1:0]) << r_cnt);
            n_cnt = r_cnt + 5'(r_width);
            if (put_data && r_next >= ((CW+1)'(1) << r_width) && r_width < 4'(CW))
                n_width = r_width + 4'd1;
        end
        if (emit) begin
            n_acc = r_acc >> 8;
            n_cnt = (r_cnt >= 5'd8) ? r_cnt - 5'd8 : 5'd0;
        end
        if (i_cfg_valid) begin
            n_min    = i_cfg_data;
            n_prefix = '0;
            n_next   = ((CW+1)'(1) << mi) + (CW+1)'(2);
            n_width  = mi + 4'd1;
            n_acc    = '0;
            n_cnt    = '0;
            n_start  = 1'b1;
            n_h      = '0;
            n_state  = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[r_h] <= wd;
        r_rd <= mem[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ret    <= S_IDLE;
            r_min    <= gle_pkg::MIN_RESET;
            r_prefix <= '0;
            r_next   <= ((CW+1)'(1) << gle_pkg::MIN_RESET) + (CW+1)'(2);
            r_width  <= gle_pkg::MIN_RESET + 4'd1;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_start  <= 1'b1;
            r_last   <= 1'b0;
            r_h      <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_min    <= n_min;
            r_prefix <= n_prefix;
            r_next   <= n_next;
            r_width  <= n_width;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_start  <= n_start;
            r_last   <= n_last;
            r_h      <= n_h;
            if (emit) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
        r_k   <= n_k;
        r_key <= n_key;
        if (emit) begin
            r_ob <= r_acc[7:0];
            r_ol <= emit_last;
        end
    end

    assign o_min       = m;
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_last_byte = r_ol;

    `GLE_ASSERT(a_idle_cnt, (r_state == S_IDLE) |-> (r_cnt < 5'd8), "bits left over in idle")
    `GLE_ASSERT(a_next_cap, r_next <= LIMIT, "next code beyond table")
    `GLE_NEVER(a_emit_busy, emit && r_ov && !i_out_ready, "byte lost on busy output")
    `GLE_NEVER(a_pop_clear, o_pop && (r_state == S_CLEAR), "pixel taken during clear")
endmodule

### src/gif_lzw_encoder_top.sv
// Takes one color-index pixel per transaction and gives GIF LZW code-stream
// bytes, LSB first, with last_byte on the final byte of each image. A pixel
// that extends a known string goes through queue pop, dictionary read, compare
// and end-of-image check, in that order. Each extra hash probe repeats the
// dictionary read and compare. A pixel that starts a new string also passes
// through the drain state, which sends out each finished byte before the
// end-of-image check. A byte waits while the output register is still held.
// The last pixel of an image also packs the final code and the end code, and
// then flushes. After reset, after a min_code_size write and after the end of
// each image, the 8192-entry dictionary memory is cleared one entry a cycle.
// Pixels that arrive during the clear wait in the two-deep input queue.
// ----------------------------------------------------------------------------
// GIF LZW encoder top level
// Input queue front end feeding the dictionary and packing engine.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_pixel,
    input  logic       i_last_pixel,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);
    gle_pkg::t_qhead head;
    logic            pop;
    logic [3:0]      min_sz;

    assign o_cfg_ready = 1'b1;

    gle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel      (i_pixel),
        .i_last_pixel (i_last_pixel),
        .i_min        (min_sz),
        .i_pop        (pop),
        .o_head       (head)
    );

    gle_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_head       (head),
        .o_pop        (pop),
        .o_min        (min_sz),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );
endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GIF LZW encoder testbench
// Feeds pixel images through a queue-fed driver under varying idle patterns
// and code sizes, predicts the packed code stream with a behavioural LZW
// encoder, and compares every output byte and its last flag in order.
// ----------------------------------------------------------------------------
module testbench;
    typedef struct {
        logic [7:0] pixel;
        logic       last;
    } t_pixel;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_pixel = 8'd0;
    logic       in_last = 1'b0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [3:0] cfg_data = 4'd0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_byte;
    logic       o_cfg_ready;

    t_pixel pixel_q[$];
    t_byte  stream_q[$];
    int     idle_mode = 0;
    int     mismatches = 0;
    logic   hold_go = 1'b0;
    logic   hold_done = 1'b0;
    int     rx_hold = 0;

    // encoder state
    logic [3:0]  enc_min = gle_pkg::MIN_RESET;
    int unsigned enc_prefix;
    int unsigned enc_next;
    int unsigned enc_width;
    int unsigned enc_accum;
    int unsigned enc_count;
    bit          enc_fresh;
    int unsigned enc_dict[int unsigned];

    gif_lzw_encoder_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel      (in_pixel),
        .i_last_pixel (in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned root_bits();
        if (enc_min < 4'd2) return 2;
        if (enc_min > 4'd8) return 8;
        return 32'(enc_min);
    endfunction

    function automatic void new_image();
        enc_dict.delete();
        enc_prefix = 0;
        enc_next   = (1 << root_bits()) + 2;
        enc_width  = root_bits() + 1;
        enc_accum  = 0;
        enc_count  = 0;
        enc_fresh  = 1'b1;
    endfunction

    function automatic void pack_code(int unsigned code);
        t_byte b;
        enc_accum |= (code & ((1 << enc_width) - 1)) << enc_count;
        enc_count += enc_width;
        while (enc_count >= 8) begin
            b.data = enc_accum[7:0];
            b.last = 1'b0;
            stream_q.push_back(b);
            enc_accum >>= 8;
            enc_count -= 8;
        end
    endfunction

    function automatic void pack_data_code(int unsigned code);
        pack_code(code);
        if (enc_next >= (1 << enc_width) && enc_width < gle_pkg::MAX_CODE_BITS)
            enc_width++;
    endfunction

    function automatic void encode_pixel(logic [7:0] pixel, logic last);
        int unsigned m;
        int unsigned sym;
        int unsigned key;
        t_byte       b;
        m   = root_bits();
        sym = 32'(pixel) & ((1 << m) - 1);
        if (enc_fresh) begin
            pack_code(1 << m);
            enc_prefix = sym;
            enc_fresh  = 1'b0;
        end else begin
            key = ((enc_prefix & 12'hfff) << 8) | sym;
            if (enc_dict.exists(key)) begin
                enc_prefix = enc_dict[key];
            end else begin
                pack_data_code(enc_prefix);
                if (enc_next < (1 << gle_pkg::MAX_CODE_BITS)) begin
                    enc_dict[key] = enc_next;
                    enc_next++;
                end
                enc_prefix = sym;
            end
        end
        if (last) begin
            pack_data_code(enc_prefix);
            pack_code((1 << m) + 1);
            if (enc_count > 0) begin
                b.data = enc_accum[7:0];
                b.last = 1'b0;
                stream_q.push_back(b);
            end
            stream_q[$].last = 1'b1;
            new_image();
        end
    endfunction

    function automatic bit roll_idle(bit sender);
        case (idle_mode)
            0: return $urandom_range(0, 99) < (sender ? 34 : 61);
            1: return $urandom_range(0, 99) < (sender ? 61 : 34);
            default: return 1'b0;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready)
                encode_pixel(in_pixel, in_last);
            if (!in_valid || o_in_ready) begin
                if (pixel_q.size() != 0 && !roll_idle(1'b1)) begin
                    in_pixel <= pixel_q[0].pixel;
                    in_last  <= pixel_q[0].last;
                    in_valid <= 1'b1;
                    void'(pixel_q.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            rx_hold   <= 12000;
            hold_done <= 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            out_ready <= (rx_hold == 0) && !roll_idle(1'b0);
            if (o_out_valid && out_ready) begin
                if (stream_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected byte %02h last %0b", o_out_byte, o_last_byte);
                end else begin
                    if (o_out_byte !== stream_q[0].data || o_last_byte !== stream_q[0].last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("byte mismatch: expected %02h/%0b got %02h/%0b",
                                     stream_q[0].data, stream_q[0].last,
                                     o_out_byte, o_last_byte);
                    end
                    void'(stream_q.pop_front());
                end
            end
        end
    end

    task automatic drain();
        while (pixel_q.size() != 0 || in_valid || stream_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_min(logic [3:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        enc_min = v;
        new_image();
        cfg_valid <= 1'b0;
    endtask

    task automatic add_pixel(logic [7:0] pixel, logic last);
        t_pixel p;
        p.pixel = pixel;
        p.last  = last;
        pixel_q.push_back(p);
    endtask

    // random image: mostly a small alphabet so strings repeat, high bits noise
    task automatic add_image(int n, int alphabet);
        logic [7:0] p;
        int unsigned mask;
        mask = (1 << root_bits()) - 1;
        for (int i = 0; i < n; i++) begin
            p = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 80)
                p = (p & ~mask[7:0]) | 8'($urandom_range(0, alphabet - 1) & mask);
            add_pixel(p, i == n - 1);
        end
    endtask

    initial begin
        logic [3:0] sizes[8];
        sizes = '{4'd2, 4'd0, 4'd15, 4'd5, 4'd1, 4'd9, 4'd3, 4'd8};
        new_image();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single-pixel image, extremes, runs
        add_pixel(8'hff, 1'b1);
        add_pixel(8'h00, 1'b0);
        add_pixel(8'hff, 1'b1);
        for (int i = 0; i < 12; i++) add_pixel(8'h00, 1'b0);
        add_pixel(8'haa, 1'b1);
        for (int i = 0; i < 8; i++) add_pixel(8'h55, i == 7);
        drain();

        // small size: codes widen quickly
        write_min(4'd2);
        for (int i = 0; i < 20; i++) add_pixel(i[7:0] ^ 8'hfc, i == 19);
        drain();

        for (int s = 0; s < 8; s++) begin
            idle_mode = s < 3 ? 0 : (s < 6 ? 1 : 2);
            write_min(sizes[s]);
            add_image($urandom_range(1, 10), 2);
            add_image($urandom_range(15, 30), 4);
            if (s == 3) begin
                add_image(60, 3);
                repeat (50) @(posedge i_clk);
                hold_go <= 1'b1;
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("testbench: errors");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/gle_pkg.sv
src/gle_front.sv
src/gle_engine.sv
src/gif_lzw_encoder_top.sv
dv/testbench.sv
